FILE: rtl/u8g_pkg.sv
// Package for the UTF-8 Greek to character-LCD code converter.
// Holds the lead codes, item and result structs, and the mapping functions.
// No dependencies.
package u8g_pkg;

  // Default display line width in columns.
  localparam int LINE_WIDTH_DEF = 20;

  // Byte values with a special meaning in the text stream.
  localparam logic [7:0] BYTE_C2      = 8'hC2;
  localparam logic [7:0] BYTE_B0      = 8'hB0;
  localparam logic [7:0] BYTE_CE      = 8'hCE;
  localparam logic [7:0] BYTE_CF      = 8'hCF;
  localparam logic [7:0] DEGREE_CODE  = 8'd223;
  localparam logic [7:0] UNKNOWN_CODE = 8'h3F;

  // Lead byte held from one request to the next.
  typedef enum logic [1:0] {
    LEAD_NONE = 2'd0,
    LEAD_C2   = 2'd1,
    LEAD_CE   = 2'd2,
    LEAD_CF   = 2'd3
  } lead_t;

  // One accepted input request.
  typedef struct packed {
    logic [7:0] text_byte;
    logic [4:0] start_col;
    logic       first_of_text;
    logic       last_of_text;
  } item_t;

  // Up to two result codes produced by one input request.
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] code0;
    logic [4:0] col0;
    logic [7:0] code1;
    logic [4:0] col1;
  } result_t;

  // Classifies a byte as a lead byte or not.
  function automatic lead_t lead_of(input logic [7:0] b);
    lead_t l;
    unique case (b)
      BYTE_C2: l = LEAD_C2;
      BYTE_CE: l = LEAD_CE;
      BYTE_CF: l = LEAD_CF;
      default: l = LEAD_NONE;
    endcase
    return l;
  endfunction

  // Code for a byte that is not a lead: a lone B0 is the degree sign.
  function automatic logic [7:0] fresh_code(input logic [7:0] b);
    return (b == BYTE_B0) ? DEGREE_CODE : b;
  endfunction

  // Code written when a lead is still held at end of text.
  function automatic logic [7:0] flush_code(input lead_t l);
    return (l == LEAD_C2) ? BYTE_C2 : UNKNOWN_CODE;
  endfunction

  // Second byte after CE: capital Greek letters to look-alikes or glyphs.
  function automatic logic [7:0] map_ce(input logic [7:0] b);
    logic [7:0] c;
    unique case (b)
      8'h91:   c = 8'h41;  // Alpha
      8'h92:   c = 8'h42;  // Beta
      8'h93:   c = 8'd0;   // Gamma, custom glyph
      8'h94:   c = 8'd1;   // Delta, custom glyph
      8'h95:   c = 8'h45;  // Epsilon
      8'h96:   c = 8'h5A;  // Zeta
      8'h97:   c = 8'h48;  // Eta
      8'h98:   c = 8'd242; // Theta
      8'h99:   c = 8'h49;  // Iota
      8'h9A:   c = 8'h4B;  // Kappa
      8'h9B:   c = 8'd2;   // Lambda, custom glyph
      8'h9C:   c = 8'h4D;  // Mu
      8'h9D:   c = 8'h4E;  // Nu
      8'h9E:   c = 8'd3;   // Xi, custom glyph
      8'h9F:   c = 8'h4F;  // Omicron
      8'hA0:   c = 8'd4;   // Pi, custom glyph
      8'hA1:   c = 8'h50;  // Rho
      8'hA2:   c = UNKNOWN_CODE;
      8'hA3:   c = 8'd246; // Sigma
      8'hA4:   c = 8'h54;  // Tau
      8'hA5:   c = 8'h59;  // Upsilon
      8'hA6:   c = 8'd5;   // Phi, custom glyph
      8'hA7:   c = 8'h58;  // Chi
      8'hA8:   c = 8'd6;   // Psi, custom glyph
      8'hA9:   c = 8'd7;   // Omega, custom glyph
      default: c = UNKNOWN_CODE;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/u8g_decode.sv
// Decoder and text state for the LCD code converter.
// Maps one registered input request to up to two codes; uses u8g_pkg.
module u8g_decode
  import u8g_pkg::*;
#(
  parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  logic    commit,
  output result_t res
);

  localparam logic [4:0] LW = 5'(LINE_WIDTH);

  lead_t      lead;
  logic [4:0] chars_written;
  logic [4:0] line_start;

  lead_t      eff_lead;
  lead_t      b_lead;
  lead_t      lead_next;
  logic [4:0] eff_cw;
  logic [4:0] eff_ls;
  logic [4:0] avail;
  logic       room0;
  logic       room1;
  logic [1:0] cnt;
  logic [7:0] code0;
  logic [7:0] code1;
  logic [4:0] chars_written_next;

  // A first byte starts from a clean count and takes its own start column.
  always_comb begin
    eff_lead = item.first_of_text ? LEAD_NONE : lead;
    eff_cw   = item.first_of_text ? 5'd0 : chars_written;
    eff_ls   = item.first_of_text ? item.start_col : line_start;
    avail    = (eff_ls < LW) ? (LW - eff_ls) : 5'd0;
    room0    = eff_cw < avail;
    room1    = ({1'b0, eff_cw} + 6'd1) < {1'b0, avail};
    b_lead   = lead_of(item.text_byte);
  end

  // Code selection for the held lead and the new byte, then end-of-text flush.
  always_comb begin
    cnt       = 2'd0;
    code0     = 8'd0;
    code1     = 8'd0;
    lead_next = LEAD_NONE;
    unique case (eff_lead)
      LEAD_NONE: begin
        if (room0) begin
          if (b_lead != LEAD_NONE) begin
            if (item.last_of_text) begin
              cnt   = 2'd1;
              code0 = flush_code(b_lead);
            end else begin
              lead_next = b_lead;
            end
          end else begin
            cnt   = 2'd1;
            code0 = fresh_code(item.text_byte);
          end
        end
      end
      LEAD_C2: begin
        if (room0) begin
          cnt = 2'd1;
          if (item.text_byte == BYTE_B0) begin
            code0 = DEGREE_CODE;
          end else begin
            code0 = BYTE_C2;
            if (room1) begin
              if (b_lead != LEAD_NONE) begin
                if (item.last_of_text) begin
                  cnt   = 2'd2;
                  code1 = flush_code(b_lead);
                end else begin
                  lead_next = b_lead;
                end
              end else begin
                cnt   = 2'd2;
                code1 = fresh_code(item.text_byte);
              end
            end
          end
        end
      end
      LEAD_CE: begin
        if (room0) begin
          cnt   = 2'd1;
          code0 = map_ce(item.text_byte);
        end
      end
      LEAD_CF: begin
        if (room0) begin
          cnt   = 2'd1;
          code0 = UNKNOWN_CODE;
        end
      end
    endcase
  end

  // Result columns and the updated count.
  always_comb begin
    res.cnt            = cnt;
    res.code0          = code0;
    res.col0           = eff_ls + eff_cw;
    res.code1          = code1;
    res.col1           = eff_ls + eff_cw + 5'd1;
    chars_written_next = eff_cw + {3'b000, cnt};
  end

  // Text state advances when the request is handed to the output buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      lead          <= LEAD_NONE;
      chars_written <= 5'd0;
      line_start    <= 5'd0;
    end else if (commit) begin
      lead          <= lead_next;
      chars_written <= chars_written_next;
      line_start    <= eff_ls;
    end
  end

endmodule

FILE: rtl/u8g_out_buf.sv
// Result buffer for the LCD code converter: holds up to two codes of one
// request and sends them one per cycle on the output stream while m_tready is high; uses u8g_pkg.
module u8g_out_buf
  import u8g_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     res,
  output logic        can_load,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  output logic        m_tlast
);

  logic [7:0] code [2];
  logic [4:0] col  [2];
  logic [1:0] rem;
  logic       head;
  logic       take;

  // The buffer frees up when it is empty or its final code leaves now.
  always_comb begin
    take     = m_tvalid && m_tready;
    can_load = (rem == 2'd0) || ((rem == 2'd1) && m_tready);
    m_tvalid = rem != 2'd0;
    m_tlast  = rem == 2'd1;
    m_tdata  = {3'b000, col[head], code[head]};
  end

  // Count of codes left and read pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      rem  <= 2'd0;
      head <= 1'b0;
    end else if (load) begin
      rem  <= res.cnt;
      head <= 1'b0;
    end else if (take) begin
      rem  <= rem - 2'd1;
      head <= ~head;
    end
  end

  // Payload storage.
  always_ff @(posedge clk) begin
    if (load) begin
      code[0] <= res.code0;
      col[0]  <= res.col0;
      code[1] <= res.code1;
      col[1]  <= res.col1;
    end
  end

endmodule

FILE: rtl/utf8_greek_to_lcd_charset.sv
// Top level of the UTF-8 Greek to character-LCD code converter.
// Instantiates u8g_decode and u8g_out_buf; uses u8g_pkg.
//
//   channel | dir | tdata (low bit up)              | tuser         | tlast
//   s_      | in  | text_byte[7:0], start_col[12:8] | first_of_text | last_of_text
//   m_      | out | lcd_code[7:0], lcd_column[12:8] | -             | run_end
//
// An input request passes through the input register and the result buffer
// before its first result shows. A byte that gives zero or one code lets the
// next input in as its code leaves; one that gives two codes holds the input
// while the result buffer drains. Throughput is set by the single output port
// of the result buffer. Reset is synchronous and clears the held lead, the count
// and the start column. Output stalls back up through the result buffer and the input register to s_tready.
module utf8_greek_to_lcd_charset
  import u8g_pkg::*;
#(
  parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // text_byte[7:0], start_col[12:8], zero[15:13]
  input  logic        s_tuser,  // first_of_text
  input  logic        s_tlast,  // last_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // lcd_code[7:0], lcd_column[12:8], zero[15:13]
  output logic        m_tlast   // run_end
);

  item_t   item;
  logic    item_valid;
  logic    can_load;
  logic    advance;
  result_t res;

  // Input register moves on whenever the result buffer can take its codes.
  always_comb begin
    advance  = item_valid && can_load;
    s_tready = !item_valid || advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.text_byte     <= s_tdata[7:0];
      item.start_col     <= s_tdata[12:8];
      item.first_of_text <= s_tuser;
      item.last_of_text  <= s_tlast;
    end
  end

  u8g_decode #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_decode (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .commit (advance),
    .res    (res)
  );

  u8g_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .res      (res),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: rtl/u8g_checker.sv
// Port checker for the LCD code converter, bound to the top level.
// Sees only the ports of utf8_greek_to_lcd_charset.
module u8g_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        s_tuser,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  // No result is shown in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result keeps its valid.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result valid dropped under stall");

  // A stalled result keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("result payload changed under stall");

  // The second code of a request follows at once, one column further on.
  a_second_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && (m_tdata[12:8] == $past(m_tdata[12:8]) + 5'd1))
    else $error("second code missing or at the wrong column");

endmodule

bind utf8_greek_to_lcd_charset u8g_checker u_checker (.*);

FILE: bench/tb.sv
// Testbench for utf8_greek_to_lcd_charset: directed table, then random texts.
// Predicts LCD codes and columns from the text byte stream and checks every result.
// Depends on u8g_pkg and the converter RTL.
module tb;
  import u8g_pkg::*;

  localparam int LW = LINE_WIDTH_DEF;
  localparam int QUIET_LIMIT = 500;
  localparam int CALM_TAIL = 100;

  // One planned input request; the expected codes are typed in for some directed rows.
  typedef struct packed {
    logic [7:0] text_b;
    logic [4:0] col;
    logic       starts_text;
    logic       ends_text;
    logic       typed;
    logic [1:0] n_codes;
    logic [7:0] code0;
    logic [4:0] col0;
    logic [7:0] code1;
    logic [4:0] col1;
  } text_req_t;

  // One code written to the display.
  typedef struct packed {
    logic [7:0] code;
    logic [4:0] column;
    logic       run_end;
  } lcd_write_t;

  // Capital Greek letters CE 91 .. CE A9 and what the display shows for them.
  localparam logic [7:0] GREEK_LOOK [25] = '{
    8'h41, 8'h42, 8'd0, 8'd1, 8'h45, 8'h5A, 8'h48, 8'd242, 8'h49, 8'h4B, 8'd2, 8'h4D,
    8'h4E, 8'd3, 8'h4F, 8'd4, 8'h50, UNKNOWN_CODE, 8'd246, 8'h54, 8'h59, 8'd5, 8'h58,
    8'd6, 8'd7
  };

  // Directed rows: byte, column, first, last, typed, count, code/column pairs.
  localparam text_req_t DIRECTED [24] = '{
    '{8'h41,   5'd0,  1'b0, 1'b0, 1'b1, 2'd1, 8'h41,        5'd0,  8'h00, 5'd0},
    '{BYTE_C2, 5'd0,  1'b0, 1'b0, 1'b1, 2'd0, 8'h00,        5'd0,  8'h00, 5'd0},
    '{BYTE_B0, 5'd0,  1'b0, 1'b0, 1'b1, 2'd1, DEGREE_CODE,  5'd1,  8'h00, 5'd0},
    '{BYTE_B0, 5'd0,  1'b0, 1'b0, 1'b1, 2'd1, DEGREE_CODE,  5'd2,  8'h00, 5'd0},
    '{BYTE_C2, 5'd0,  1'b0, 1'b0, 1'b1, 2'd0, 8'h00,        5'd0,  8'h00, 5'd0},
    '{8'h7A,   5'd0,  1'b0, 1'b0, 1'b1, 2'd2, BYTE_C2,      5'd3,  8'h7A, 5'd4},
    '{BYTE_CE, 5'd0,  1'b0, 1'b0, 1'b1, 2'd0, 8'h00,        5'd0,  8'h00, 5'd0},
    '{8'h91,   5'd0,  1'b0, 1'b0, 1'b0, 2'd0, 8'h00,        5'd0,  8'h00, 5'd0},
    '{BYTE_CE, 5'd0,  1'b0, 1'b0, 1'b1, 2'd0, 8'h00,        5'd0,  8'h00, 5'd0},
    '{8'h98,   5'd0,  1'b0, 1'b0, 1'b0, 2'd0, 8'h00,        5'd0,  8'h00, 5'd0},
    '{BYTE_CE, 5'd0,  1'b0, 1'b0, 1'b1, 2'd0, 8'h00,        5'd0,  8'h00, 5'd0},
    '{8'h00,   5'd0,  1'b0, 1'b0, 1'b1, 2'd1, UNKNOWN_CODE, 5'd7,  8'h00, 5'd0},
    '{BYTE_CF, 5'd0,  1'b0, 1'b0, 1'b1, 2'd0, 8'h00,        5'd0,  8'h00, 5'd0},
    '{BYTE_CE, 5'd0,  1'b0, 1'b0, 1'b1, 2'd1, UNKNOWN_CODE, 5'd8,  8'h00, 5'd0},
    '{8'h00,   5'd0,  1'b0, 1'b0, 1'b1, 2'd1, 8'h00,        5'd9,  8'h00, 5'd0},
    '{8'hFF,   5'd0,  1'b0, 1'b0, 1'b1, 2'd1, 8'hFF,        5'd10, 8'h00, 5'd0},
    '{BYTE_CE, 5'd0,  1'b0, 1'b1, 1'b1, 2'd1, UNKNOWN_CODE, 5'd11, 8'h00, 5'd0},
    '{8'h41,   5'd31, 1'b1, 1'b0, 1'b1, 2'd0, 8'h00,        5'd0,  8'h00, 5'd0},
    '{BYTE_C2, 5'd0,  1'b0, 1'b1, 1'b1, 2'd0, 8'h00,        5'd0,  8'h00, 5'd0},
    '{BYTE_C2, 5'd19, 1'b1, 1'b0, 1'b1, 2'd0, 8'h00,        5'd0,  8'h00, 5'd0},
    '{8'h41,   5'd0,  1'b0, 1'b1, 1'b0, 2'd0, 8'h00,        5'd0,  8'h00, 5'd0},
    '{BYTE_CF, 5'd18, 1'b1, 1'b1, 1'b1, 2'd1, UNKNOWN_CODE, 5'd18, 8'h00, 5'd0},
    '{8'h42,   5'd20, 1'b1, 1'b1, 1'b1, 2'd0, 8'h00,        5'd0,  8'h00, 5'd0},
    '{BYTE_C2, 5'd0,  1'b1, 1'b1, 1'b1, 2'd1, BYTE_C2,      5'd0,  8'h00, 5'd0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;  // text_byte[7:0], start_col[12:8], zero[15:13]
  logic        s_tuser = 1'b0;  // first_of_text
  logic        s_tlast = 1'b0;  // last_of_text
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;  // lcd_code[7:0], lcd_column[12:8], zero[15:13]
  logic        m_tlast;  // run_end

  // Predictor state for the current text.
  lead_t      held_lead = LEAD_NONE;
  logic [4:0] chars_done = '0;
  logic [4:0] line_base = '0;

  text_req_t  text_plan[$];
  lcd_write_t new_writes[$];
  lcd_write_t writes_due[$];
  int         mismatches = 0;
  int         quiet_cycles = 0;
  int         stall_left = 0;
  logic       calm = 1'b0;

  utf8_greek_to_lcd_charset dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Columns still free on this line.
  function automatic int room_left();
    return (line_base < LW) ? LW - line_base : 0;
  endfunction

  function automatic logic [7:0] greek_code(input logic [7:0] b);
    if (b >= 8'h91 && b <= 8'hA9) return GREEK_LOOK[5'(b - 8'h91)];
    return UNKNOWN_CODE;
  endfunction

  // Writes one code unless the line is already full.
  function automatic void put_code(input logic [7:0] code);
    if (chars_done >= room_left()) return;
    new_writes.push_back('{code: code, column: line_base + chars_done, run_end: 1'b0});
    chars_done = chars_done + 5'd1;
  endfunction

  // A byte with no lead in front of it: either a new lead or a code of its own.
  function automatic void take_plain(input logic [7:0] b);
    if (chars_done >= room_left()) return;
    case (b)
      BYTE_C2: held_lead = LEAD_C2;
      BYTE_CE: held_lead = LEAD_CE;
      BYTE_CF: held_lead = LEAD_CF;
      BYTE_B0: put_code(DEGREE_CODE);
      default: put_code(b);
    endcase
  endfunction

  // Works out the display writes that one accepted text byte causes.
  function automatic void convert_text_byte(input text_req_t r);
    lead_t lead;
    new_writes.delete();
    if (r.starts_text) begin
      held_lead = LEAD_NONE;
      chars_done = '0;
      line_base = r.col;
    end
    lead = held_lead;
    held_lead = LEAD_NONE;
    case (lead)
      LEAD_C2: begin
        if (r.text_b == BYTE_B0) begin
          put_code(DEGREE_CODE);
        end else begin
          put_code(BYTE_C2);
          take_plain(r.text_b);
        end
      end
      LEAD_CE: put_code(greek_code(r.text_b));
      LEAD_CF: put_code(UNKNOWN_CODE);
      default: take_plain(r.text_b);
    endcase
    // A lead still held at the end of the text is flushed.
    if (r.ends_text && held_lead != LEAD_NONE) begin
      lead = held_lead;
      held_lead = LEAD_NONE;
      put_code((lead == LEAD_C2) ? BYTE_C2 : UNKNOWN_CODE);
    end
    if (new_writes.size() > 0) new_writes[new_writes.size() - 1].run_end = 1'b1;
  endfunction

  // Appends one random text, mostly well formed, sometimes pure noise.
  function automatic void plan_random_text();
    logic [7:0] bytes_q[$];
    text_req_t  r;
    int         len;
    logic [4:0] col;
    len = $urandom_range(1, 24);
    if ($urandom_range(0, 9) == 0) begin
      for (int k = 0; k < len; k++) begin
        r = '0;
        r.text_b = 8'($urandom);
        r.col = 5'($urandom);
        r.starts_text = ($urandom_range(0, 5) == 0);
        r.ends_text = ($urandom_range(0, 5) == 0);
        text_plan.push_back(r);
      end
      return;
    end
    col = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 16));
    while (bytes_q.size() < len) begin
      case ($urandom_range(0, 9))
        0, 1, 2: bytes_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        3: begin
          bytes_q.push_back(BYTE_CE);
          bytes_q.push_back(8'($urandom_range(8'h91, 8'hA9)));
        end
        4: begin
          bytes_q.push_back(BYTE_CE);
          bytes_q.push_back(8'($urandom));
        end
        5: begin
          bytes_q.push_back(BYTE_C2);
          bytes_q.push_back(BYTE_B0);
        end
        6: bytes_q.push_back(BYTE_B0);
        7: begin
          bytes_q.push_back(BYTE_CF);
          bytes_q.push_back(8'($urandom));
        end
        8: begin
          bytes_q.push_back(BYTE_C2);
          bytes_q.push_back(8'($urandom));
        end
        default: bytes_q.push_back(8'($urandom));
      endcase
    end
    // Occasionally cut the text right after a lead so that it gets flushed.
    if ($urandom_range(0, 5) == 0) begin
      bytes_q.push_back(($urandom_range(0, 2) == 0) ? BYTE_C2 :
                        ($urandom_range(0, 1) == 0) ? BYTE_CE : BYTE_CF);
    end
    foreach (bytes_q[k]) begin
      r = '0;
      r.text_b = bytes_q[k];
      r.col = (k == 0) ? col : 5'($urandom);
      r.starts_text = (k == 0);
      r.ends_text = (k == bytes_q.size() - 1);
      text_plan.push_back(r);
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  // Request source: directed table first, then random texts.
  initial begin
    text_req_t r;
    foreach (DIRECTED[k]) text_plan.push_back(DIRECTED[k]);
    while (text_plan.size() < 950) plan_random_text();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < text_plan.size(); i++) begin
      r = text_plan[i];
      calm <= (i >= text_plan.size() - CALM_TAIL);
      if (i < text_plan.size() - CALM_TAIL && $urandom_range(0, 7) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata <= {3'b000, r.col, r.text_b};
      s_tuser <= r.starts_text;
      s_tlast <= r.ends_text;
      @(posedge clk);
      while (!s_tready) @(posedge clk);

      // The predictor always runs so that its state follows the text.
      convert_text_byte(r);
      if (r.typed) begin
        if (r.n_codes > 0) begin
          writes_due.push_back('{code: r.code0, column: r.col0, run_end: (r.n_codes == 1)});
        end
        if (r.n_codes > 1) begin
          writes_due.push_back('{code: r.code1, column: r.col1, run_end: 1'b1});
        end
      end else begin
        foreach (new_writes[k]) writes_due.push_back(new_writes[k]);
      end
    end
    s_tvalid <= 1'b0;

    while (writes_due.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result sink: random stall bursts, result checking and the watchdog.
  always @(posedge clk) begin
    lcd_write_t want;
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(1, 14) - 1;
    end else begin
      m_tready <= 1'b1;
    end

    if (m_tvalid && m_tready) begin
      if (writes_due.size() == 0) begin
        note_mismatch($sformatf("unexpected result code %0d column %0d run_end %0b",
                                m_tdata[7:0], m_tdata[12:8], m_tlast));
      end else begin
        want = writes_due.pop_front();
        if (m_tdata[7:0] !== want.code) begin
          note_mismatch($sformatf("lcd_code expected %0d got %0d", want.code, m_tdata[7:0]));
        end
        if (m_tdata[12:8] !== want.column) begin
          note_mismatch($sformatf("lcd_column expected %0d got %0d",
                                  want.column, m_tdata[12:8]));
        end
        if (m_tlast !== want.run_end) begin
          note_mismatch($sformatf("run_end expected %0b got %0b", want.run_end, m_tlast));
        end
      end
    end

    if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
